// ===== design/fit_policy_block_allocator_unit_defines.svh =====
// Assertion macros used by the fit policy block allocator top level.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPBA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPBA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fpba_pkg.sv =====
// Types, constants and codes of the fit policy block allocator.
`default_nettype none

package fpba_pkg;

    localparam int BLOCKS    = 16;
    localparam int SIZE_BITS = 16;

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W = $clog2(BLOCKS + 1);

    localparam int OPCODE_W   = 1;
    localparam int BIDX_W     = 4;
    localparam int FSIZE_W    = 16;
    localparam int TAG_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int CMP_W      = (SIZE_BITS > FSIZE_W) ? SIZE_BITS : FSIZE_W;

    typedef logic [SIZE_BITS-1:0] t_size;
    typedef logic [IDX_W-1:0]     t_idx;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 1'b0,
        OP_ALLOC = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_LOADED = 2'd0,
        STAT_PLACED = 2'd1,
        STAT_NOFIT  = 2'd2
    } t_status;

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } t_fit_mode;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_FIN  = 2'd2
    } t_scan_state;

    typedef struct packed {
        logic  rd_en;
        t_idx  rd_addr;
        logic  wr_en;
        t_idx  wr_addr;
        t_size wr_data;
    } t_ram_req;

    typedef struct packed {
        t_status              status;
        logic [BIDX_W-1:0]    block;
        logic [FSIZE_W-1:0]   remaining;
        logic [TAG_W-1:0]     tag;
    } t_result;

endpackage

`default_nettype wire

// ===== design/fpba_in_if.sv =====
// Request channel: valid/ready handshake with the allocator's input word.
`default_nettype none

interface fpba_in_if;
    import fpba_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BIDX_W-1:0]   block_index;
    logic [FSIZE_W-1:0]  size_value;
    logic [TAG_W-1:0]    request_tag;

    modport source (output valid, opcode, block_index, size_value, request_tag,
                    input ready);
    modport sink   (input valid, opcode, block_index, size_value, request_tag,
                    output ready);
endinterface

`default_nettype wire

// ===== design/fpba_out_if.sv =====
// Result channel: valid/ready handshake with the allocator's result word.
`default_nettype none

interface fpba_out_if;
    import fpba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   chosen_block;
    logic [FSIZE_W-1:0]  remaining_size;
    logic [TAG_W-1:0]    tag_out;

    modport source (output valid, status, chosen_block, remaining_size, tag_out,
                    input ready);
    modport sink   (input valid, status, chosen_block, remaining_size, tag_out,
                    output ready);
endinterface

`default_nettype wire

// ===== design/fpba_table_ram.sv =====
// Free size table: one write port, one read port with registered read data.
`default_nettype none

module fpba_table_ram (
    input  wire logic              i_clk,
    input  wire fpba_pkg::t_ram_req i_req,
    output fpba_pkg::t_size        o_rd_data
);
    import fpba_pkg::*;

    t_size r_mem [BLOCKS];
    t_size r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/fpba_scan.sv =====
// Sequencer: takes a word, writes a load or scans the table one entry a cycle, writes back the pick.
`default_nettype none

module fpba_scan (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [fpba_pkg::MODE_W-1:0] i_fit_mode,
    input  wire logic [fpba_pkg::COUNT_W-1:0] i_block_count,
    fpba_in_if.sink                          i_in,
    output fpba_pkg::t_ram_req               o_ram_req,
    input  wire fpba_pkg::t_size             i_rd_data,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output fpba_pkg::t_result                o_res
);
    import fpba_pkg::*;

    t_scan_state        r_state, n_state;
    logic               r_eval_vld, n_eval_vld;
    t_idx               r_eval_idx, n_eval_idx;
    logic [CNT_W-1:0]   r_issue, n_issue;
    logic [CNT_W-1:0]   r_limit, n_limit;
    logic [FSIZE_W-1:0] r_size, n_size;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic               r_found, n_found;
    t_idx               r_pick, n_pick;
    t_size              r_best, n_best;
    t_status            r_status, n_status;
    logic [BIDX_W-1:0]  r_blk, n_blk;
    logic               r_wr_pend, n_wr_pend;

    logic               fits;
    t_size              left;
    logic               take;
    logic               first_mode;
    logic               issue;
    logic               load_in_range;
    logic [CNT_W-1:0]   limit;

    assign fits = CMP_W'(i_rd_data) >= CMP_W'(r_size);
    assign left = i_rd_data - SIZE_BITS'(r_size);
    assign first_mode = !(r_mode == FIT_BEST || r_mode == FIT_WORST);
    assign load_in_range = 32'(i_in.block_index) < BLOCKS;
    assign limit = (32'(i_block_count) > BLOCKS) ? CNT_W'(BLOCKS)
                                                 : CNT_W'(i_block_count);

    // Pick rule for the entry whose read data is valid this cycle.
    always_comb begin
        case (r_mode)
            FIT_BEST:  take = fits && (!r_found || left < r_best);
            FIT_WORST: take = fits && (!r_found || left > r_best);
            default:   take = fits && !r_found;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_eval_vld = r_eval_vld;
        n_eval_idx = r_eval_idx;
        n_issue    = r_issue;
        n_limit    = r_limit;
        n_size     = r_size;
        n_mode     = r_mode;
        n_tag      = r_tag;
        n_found    = r_found;
        n_pick     = r_pick;
        n_best     = r_best;
        n_status   = r_status;
        n_blk      = r_blk;
        n_wr_pend  = r_wr_pend;
        o_ram_req  = '0;
        o_res_valid = 1'b0;
        issue      = 1'b0;
        i_in.ready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_tag = i_in.request_tag;
                    case (i_in.opcode)
                        OP_ALLOC: begin
                            n_size     = i_in.size_value;
                            n_mode     = i_fit_mode;
                            n_limit    = limit;
                            n_issue    = '0;
                            n_found    = 1'b0;
                            n_eval_vld = 1'b0;
                            n_state    = S_SCAN;
                        end
                        default: begin
                            n_status  = STAT_LOADED;
                            n_blk     = i_in.block_index;
                            n_pick    = IDX_W'(i_in.block_index);
                            n_best    = load_in_range ? SIZE_BITS'(i_in.size_value) : '0;
                            n_wr_pend = load_in_range;
                            n_state   = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // stop issuing reads once first fit has its hit
                issue = (r_issue < r_limit) && !(first_mode && r_found);
                o_ram_req.rd_en   = issue;
                o_ram_req.rd_addr = r_issue[IDX_W-1:0];
                n_issue    = issue ? r_issue + 1'b1 : r_issue;
                n_eval_vld = issue;
                n_eval_idx = r_issue[IDX_W-1:0];
                if (r_eval_vld && take) begin
                    n_found = 1'b1;
                    n_pick  = r_eval_idx;
                    n_best  = left;
                end
                if (!issue && !r_eval_vld) begin
                    n_status  = r_found ? STAT_PLACED : STAT_NOFIT;
                    n_blk     = r_found ? BIDX_W'(r_pick) : '0;
                    n_best    = r_found ? r_best : '0;
                    n_wr_pend = r_found;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    o_ram_req.wr_en   = r_wr_pend;
                    o_ram_req.wr_addr = r_pick;
                    o_ram_req.wr_data = r_best;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.status    = r_status;
    assign o_res.block     = r_blk;
    assign o_res.remaining = FSIZE_W'(r_best);
    assign o_res.tag       = r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_eval_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_eval_vld <= n_eval_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval_idx <= n_eval_idx;
        r_issue    <= n_issue;
        r_limit    <= n_limit;
        r_size     <= n_size;
        r_mode     <= n_mode;
        r_tag      <= n_tag;
        r_found    <= n_found;
        r_pick     <= n_pick;
        r_best     <= n_best;
        r_status   <= n_status;
        r_blk      <= n_blk;
        r_wr_pend  <= n_wr_pend;
    end

endmodule

`default_nettype wire

// ===== design/fit_policy_block_allocator_unit.sv =====
// Top level of the fit policy block allocator: config registers, sequencer, table, result register.
`default_nettype none

// The unit keeps a table of free sizes, one 16-bit entry per memory block
// (16 entries), in a single-port-read, single-port-write synchronous RAM.
// A load word writes one entry and answers status "loaded" with the stored
// size; an index past the table writes nothing and answers a remaining size
// of zero. An allocate word scans entries 0 to block_count-1 and picks one
// under fit_mode: first fit takes the lowest index that fits, best fit the
// least leftover, worst fit the greatest leftover, ties to the lowest index;
// fit mode 3 acts as first fit and a block_count above 16 acts as 16. The
// pick is reduced by the request and reported with what is left; if nothing
// fits, the status is "no fit", block and remaining size read zero and the
// table is untouched. Entries hold nothing defined until loaded: allocate
// only over loaded entries. Timing: the table has one read port, so a scan
// reads one entry per cycle. A load goes from accept to the result register;
// an allocate steps through accept, one read per scanned entry, the registered
// read data, the close of the scan and the write-back with the result. First
// fit stops reading one entry past its first hit. One word is in work at a
// time; the finished result sits in an output register, so a new word is
// taken while the last result waits.
// Write fit_mode and block_count only while the unit is idle.
module fit_policy_block_allocator_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fpba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fpba_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    fpba_in_if.sink                             i_in,
    fpba_out_if.source                          o_out
);
    import fpba_pkg::*;

    `include "fit_policy_block_allocator_unit_defines.svh"

    // configuration registers
    logic [MODE_W-1:0]  r_fit_mode, n_fit_mode;
    logic [COUNT_W-1:0] r_block_count, n_block_count;

    // sequencer to table
    t_ram_req           ram_req;
    t_size              rd_data;

    // sequencer to result register
    logic               res_valid;
    logic               res_ready;
    t_result            res;

    // result register
    logic               r_out_valid, n_out_valid;
    t_result            r_out_res;

    // Decode register writes; unknown indexes drop.
    always_comb begin
        n_fit_mode    = r_fit_mode;
        n_block_count = r_block_count;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FIT_MODE:    n_fit_mode    = i_cfg_wdata[MODE_W-1:0];
                REG_BLOCK_COUNT: n_block_count = i_cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= FIT_FIRST;
            r_block_count <= BLOCK_COUNT_RST;
        end else begin
            r_fit_mode    <= n_fit_mode;
            r_block_count <= n_block_count;
        end
    end

    fpba_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fit_mode    (r_fit_mode),
        .i_block_count (r_block_count),
        .i_in          (i_in),
        .o_ram_req     (ram_req),
        .i_rd_data     (rd_data),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    fpba_table_ram u_table (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    // Result register: load when empty or being drained, hold otherwise.
    assign res_ready = !r_out_valid || o_out.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_res <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_res.status;
    assign o_out.chosen_block   = r_out_res.block;
    assign o_out.remaining_size = r_out_res.remaining;
    assign o_out.tag_out        = r_out_res.tag;

    // A taken word keeps the unit busy for at least the next cycle.
    `FPBA_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready, "ready after accept")
    // The table is never read and written in the same cycle.
    `FPBA_ASSERT_NOW(a_no_rw_overlap, ram_req.rd_en, !ram_req.wr_en, "table read and write overlap")
    // A no-fit result carries block zero and size zero.
    `FPBA_ASSERT_NOW(a_nofit_zero, r_out_valid && r_out_res.status == STAT_NOFIT, r_out_res.block == '0 && r_out_res.remaining == '0, "no-fit result not zeroed")
    // A write-back leaves the result slot filled.
    `FPBA_ASSERT_NEXT(a_wb_sets_out, ram_req.wr_en && res_valid, r_out_valid, "write-back without result")

endmodule

`default_nettype wire

// ===== dv/fit_policy_block_allocator_unit_checker.sv =====
// Result checker for the fit policy block allocator: tracks config, predicts, compares.
`timescale 1ns / 100ps

module fit_policy_block_allocator_unit_checker
    import fpba_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    fpba_in_if                         i_req,
    fpba_out_if                        i_res,
    output int                         o_fail_count,
    output int                         o_pending
);

    logic [SIZE_BITS-1:0] free_sizes [0:BLOCKS-1];
    logic [MODE_W-1:0]    mode_sel;
    logic [COUNT_W-1:0]   scan_count;
    t_result              awaited_results [$];
    int                   errors;

    initial begin
        for (int k = 0; k < BLOCKS; k++) begin
            free_sizes[k] = '0;
        end
        errors = 0;
    end

    // Apply one word to the shadow table and return the result it must produce.
    task automatic allocate_or_load(input logic [OPCODE_W-1:0] op,
                                    input logic [BIDX_W-1:0]   idx,
                                    input logic [FSIZE_W-1:0]  size,
                                    input logic [TAG_W-1:0]    tag,
                                    output t_result            res);
        int                   scan_len;
        logic                 found;
        logic                 stop;
        logic [BIDX_W-1:0]    pick;
        logic [SIZE_BITS-1:0] left;
        logic [SIZE_BITS-1:0] best;
        res.tag = tag;
        if (op == OP_LOAD) begin
            free_sizes[idx] = size;
            res.status      = STAT_LOADED;
            res.block       = idx;
            res.remaining   = size;
        end else begin
            scan_len = (scan_count > BLOCKS) ? BLOCKS : int'(scan_count);
            found    = 1'b0;
            stop     = 1'b0;
            pick     = '0;
            best     = '0;
            for (int j = 0; j < scan_len; j++) begin
                if (!stop && free_sizes[j] >= size) begin
                    left = free_sizes[j] - size;
                    if (mode_sel == FIT_BEST) begin
                        if (!found || left < best) begin
                            found = 1'b1;
                            pick  = BIDX_W'(j);
                            best  = left;
                        end
                    end else if (mode_sel == FIT_WORST) begin
                        if (!found || left > best) begin
                            found = 1'b1;
                            pick  = BIDX_W'(j);
                            best  = left;
                        end
                    end else begin
                        // first fit, and the spare mode code acting as first fit
                        found = 1'b1;
                        pick  = BIDX_W'(j);
                        best  = left;
                        stop  = 1'b1;
                    end
                end
            end
            if (found) begin
                free_sizes[pick] = best;
                res.status       = STAT_PLACED;
                res.block        = pick;
                res.remaining    = best;
            end else begin
                res.status    = STAT_NOFIT;
                res.block     = '0;
                res.remaining = '0;
            end
        end
    endtask

    function automatic int field_off(string what, int want, int got);
        if (want == got) return 0;
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        int      bad;
        if (!i_rst_n) begin
            mode_sel   = FIT_FIRST;
            scan_count = BLOCK_COUNT_RST;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FIT_MODE) begin
                    mode_sel = i_cfg_wdata[MODE_W-1:0];
                end else if (i_cfg_index == REG_BLOCK_COUNT) begin
                    scan_count = i_cfg_wdata[COUNT_W-1:0];
                end
            end
            if (i_res.valid && i_res.ready) begin
                got.status    = t_status'(i_res.status);
                got.block     = i_res.chosen_block;
                got.remaining = i_res.remaining_size;
                got.tag       = i_res.tag_out;
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none actual status %0d tag %0d",
                             $time, got.status, got.tag);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    bad  = field_off("status", want.status, got.status)
                         + field_off("chosen_block", want.block, got.block)
                         + field_off("remaining_size", want.remaining, got.remaining)
                         + field_off("tag_out", want.tag, got.tag);
                    if (bad != 0) errors++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                allocate_or_load(i_req.opcode, i_req.block_index, i_req.size_value,
                                 i_req.request_tag, want);
                // append at the tail
                awaited_results.insert(awaited_results.size(), want);
            end
        end
        o_fail_count <= errors;
        o_pending    <= awaited_results.size();
    end

endmodule

// ===== dv/fit_policy_block_allocator_unit_tb.sv =====
// Testbench top for the fit policy block allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module fit_policy_block_allocator_unit_tb;
    import fpba_pkg::*;

    localparam int  HALF_PERIOD   = 10;
    localparam int  RESET_CYCLES  = 11;
    // Quiet time after the last result, with margin past the longest allocate.
    localparam int  SETTLE_CYCLES = 25;
    // Receiver hold-off long enough to back the block up into its input.
    localparam int  LONG_HOLD     = 400;
    localparam longint RUN_LIMIT_NS = 64'd30_000_000;

    // Mode code 3 has no policy of its own; the block treats it as first fit.
    localparam logic [MODE_W-1:0] FIT_SPARE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count;
    int                    words_pending;

    // Shared idling controls: calm drops all gaps, hold_requested asks for one long stall.
    bit calm;
    bit hold_requested;
    bit hold_done;

    fpba_in_if  req_ch ();
    fpba_out_if res_ch ();

    fit_policy_block_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (req_ch),
        .o_out       (res_ch)
    );

    fit_policy_block_allocator_unit_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // No gap or a short one most of the time, a medium one at times, now and then a long one.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    // Offer one word after a random gap and hold it until the block takes it.
    // Valid is left high on return so the next word can follow back to back.
    task automatic send_word(input t_opcode            op,
                             input logic [BIDX_W-1:0]  idx,
                             input logic [FSIZE_W-1:0] size,
                             input logic [TAG_W-1:0]   tag);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.block_index <= idx;
        req_ch.size_value  <= size;
        req_ch.request_tag <= tag;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Loads refill the table with a mix of sizes; small multiples of 1000 make
    // exact fits and equal leftovers likely, so the tie rules get exercised.
    task automatic send_random_word();
        int                 roll;
        t_opcode            op;
        logic [FSIZE_W-1:0] size;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            op = OP_LOAD;
            case ($urandom_range(0, 2))
                0:       size = FSIZE_W'($urandom_range(0, 65535));
                1:       size = FSIZE_W'($urandom_range(0, 6) * 1000);
                default: size = FSIZE_W'($urandom_range(60000, 65535));
            endcase
        end else begin
            op   = OP_ALLOC;
            roll = $urandom_range(0, 99);
            if (roll < 10)      size = '0;
            else if (roll < 50) size = FSIZE_W'($urandom_range(1, 2000));
            else if (roll < 75) size = FSIZE_W'($urandom_range(1, 6) * 1000);
            else if (roll < 90) size = FSIZE_W'($urandom_range(0, 65535));
            else                size = '1;
        end
        send_word(op, BIDX_W'($urandom_range(0, 15)), size, TAG_W'($urandom_range(0, 255)));
    endtask

    // Drop valid, wait until every result is back, then let the block go quiet.
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Program both registers on an idle block, then run a stretch of random words.
    task automatic run_phase(input logic [MODE_W-1:0]     mode,
                             input logic [CFG_DATA_W-1:0] count,
                             input int                    words,
                             input bit                    quiet,
                             input bit                    squeeze);
        write_reg(REG_FIT_MODE, CFG_DATA_W'(mode));
        write_reg(REG_BLOCK_COUNT, count);
        calm = quiet;
        if (squeeze) hold_requested = 1'b1;
        repeat (words) send_random_word();
        calm = 1'b0;
        settle();
    endtask

    // Receiver: ready comes in bursts separated by random gaps; once asked,
    // hold off for a long stretch while the sender keeps pushing words.
    initial begin
        int gap;
        res_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_requested && !hold_done) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                gap = idle_gap();
                if (gap > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                res_ch.ready <= 1'b1;
                repeat (calm ? 16 : $urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin
        calm               = 1'b0;
        hold_requested     = 1'b0;
        hold_done          = 1'b0;
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.opcode      <= OP_LOAD;
        req_ch.block_index <= '0;
        req_ch.size_value  <= '0;
        req_ch.request_tag <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings (first fit over all 16 entries).
        // Load every entry first so no scan ever reads an unwritten one.
        send_word(OP_LOAD, 4'd0, 16'd0, 8'd0);
        send_word(OP_LOAD, 4'd1, 16'hFFFF, 8'd255);
        send_word(OP_LOAD, 4'd2, 16'd500, 8'd2);
        send_word(OP_LOAD, 4'd3, 16'd500, 8'd3);
        send_word(OP_LOAD, 4'd4, 16'd40, 8'd4);
        send_word(OP_LOAD, 4'd5, 16'd1200, 8'd5);
        send_word(OP_LOAD, 4'd6, 16'd40, 8'd6);
        for (int k = 7; k < BLOCKS; k++) begin
            send_word(OP_LOAD, BIDX_W'(k), FSIZE_W'(k * 100), TAG_W'(k));
        end
        // zero request fits the empty entry 0
        send_word(OP_ALLOC, 4'd0, 16'd0, 8'd255);
        // exact fit of the full-size entry leaves nothing
        send_word(OP_ALLOC, 4'd0, 16'hFFFF, 8'd0);
        // nothing left that large: no fit, table untouched
        send_word(OP_ALLOC, 4'd0, 16'hFFFF, 8'd17);
        send_word(OP_ALLOC, 4'd9, 16'd40, 8'd18);
        // block index is ignored on an allocate
        send_word(OP_ALLOC, 4'd15, 16'd1, 8'd19);
        settle();

        run_phase(FIT_BEST, 5'd16, 200, 1'b0, 1'b0);
        run_phase(FIT_WORST, 5'd16, 200, 1'b0, 1'b0);
        // spare mode code with a count past the table size
        run_phase(FIT_SPARE, 5'd31, 120, 1'b0, 1'b0);
        run_phase(FIT_FIRST, 5'd1, 100, 1'b1, 1'b0);
        // zero count: every allocate misses, loads still land
        run_phase(FIT_BEST, 5'd0, 60, 1'b0, 1'b0);
        run_phase(FIT_WORST, 5'd5, 150, 1'b0, 1'b0);
        run_phase(FIT_FIRST, 5'd16, 200, 1'b0, 1'b1);
        run_phase(FIT_BEST, 5'd9, 220, 1'b0, 1'b0);

        if (fail_count == 0 && words_pending == 0) begin
            $display("PASS fit_policy_block_allocator_unit");
        end else begin
            $display("FAIL fit_policy_block_allocator_unit");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL fit_policy_block_allocator_unit");
        $finish;
    end

endmodule
